### rtl/core/itf_pkg.sv
// Shared types, constants and helper functions of the integer to text formatter.
// No dependencies; every other file of the block but itf_ram imports this package.
package itf_pkg;

    // Sizing
    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 64;
    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 6;
    localparam int WIDTH_W    = 7;
    localparam int PREC_W     = 7;
    localparam int FLAGS_W    = 7;
    localparam int IN_TDATA_W = 96;
    localparam int CH_W       = 8;
    localparam int DIGIT_W    = 6;
    localparam int POS_W      = 8;
    localparam int MAG_BYTES  = (VALUE_BITS + 7) / 8;
    localparam int MAG_W      = MAG_BYTES * 8;
    localparam int BIDX_W     = (MAG_BYTES > 1) ? $clog2(MAG_BYTES) : 1;
    localparam int DIG_AW     = $clog2(VALUE_BITS);
    localparam int ND_W       = $clog2(VALUE_BITS + 1);
    localparam int Q_DEPTH    = 2;

    // Flag bit positions
    localparam int FL_ZERO  = 0;
    localparam int FL_SIGN  = 1;
    localparam int FL_PLUS  = 2;
    localparam int FL_SPACE = 3;
    localparam int FL_LEFT  = 4;
    localparam int FL_PREF  = 5;
    localparam int FL_UPPER = 6;

    // Radix codes
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    // Characters
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [POS_W-1:0] MAX_CHARS_P = POS_W'(MAX_CHARS);

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic [PREC_W-1:0]  precision;
        logic [WIDTH_W-1:0] width;
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] value;
    } itf_in_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [MAG_W-1:0]   mag;
        logic [RADIX_W-1:0] radix;
        logic [WIDTH_W-1:0] width;
        logic [PREC_W-1:0]  prec;
        logic               sign_en;
        logic [CH_W-1:0]    sign_ch;
        logic [1:0]         pref_len;
        logic               zero;
        logic               left;
        logic               upper;
    } itf_desc_t;

    // Index of the most significant nonzero byte (0 when all bytes are zero)
    function automatic logic [BIDX_W-1:0] top_byte(input logic [MAG_W-1:0] m);
        logic [BIDX_W-1:0] idx;
        idx = '0;
        for (int j = 0; j < MAG_BYTES; j++) begin
            if (m[j*8 +: 8] != 8'd0) begin
                idx = BIDX_W'(j);
            end
        end
        return idx;
    endfunction

    // One byte of long division by the radix: returns {quotient byte, remainder}
    function automatic logic [8+DIGIT_W-1:0] div_byte(
        input logic [DIGIT_W-1:0] rem,
        input logic [7:0]         chunk,
        input logic [RADIX_W-1:0] radix
    );
        logic [DIGIT_W:0] r;
        logic [7:0]       q;
        r = {1'b0, rem};
        q = '0;
        for (int k = 7; k >= 0; k--) begin
            r = {r[DIGIT_W-1:0], chunk[k]};
            if (r >= {1'b0, radix}) begin
                r    = r - {1'b0, radix};
                q[k] = 1'b1;
            end
        end
        return {q, r[DIGIT_W-1:0]};
    endfunction

    function automatic logic [CH_W-1:0] digit_char(
        input logic [DIGIT_W-1:0] d,
        input logic               upper
    );
        logic [CH_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CH_ZERO + CH_W'(d);
        end
        else begin
            c = (upper ? CH_A_UP : CH_A_LO) + CH_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

### rtl/core/integer_to_text_formatter.sv
// Top level of the integer to text formatter: stream ports, field packing, wiring.
// Depends on itf_pkg, itf_front, itf_queue and itf_back.
//
// Formats one integer per request, printf style, and streams the text out one
// ASCII character per beat with tlast on the final character. A request carries
// the value, radix (2 to 36), minimum width, minimum digit count and flags; the
// text is leading spaces, sign, 0 / 0x / 0X prefix, zero fill, digits and, when
// left-justified, trailing spaces. A radix outside 2 to 36 is consumed and
// produces nothing. Text longer than MAX_CHARS is cut to MAX_CHARS characters and
// every beat of such a request carries tuser = 1. Flow: the front classifies a
// request and registers it, then hands it through a two-entry queue, so up to
// three requests can be taken while the back is busy. The back works on one
// request at a time: for each digit it finds the top nonzero byte of the
// magnitude, then divides the significant bytes from the top down (the divider
// retires eight quotient bits per cycle against the radix); it then lays out the
// text (ST_LAY_A, ST_LAY_B), and for each character reads the digit memory and
// loads the output register, waiting while the output is stalled. The back
// accepts the next queued request once the last character is in the output
// register. Reset is asynchronous and active low; no clearing pass is needed.
module integer_to_text_formatter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // value[63:0], radix[69:64], width[76:70], precision[83:77], flags[90:84], zeros
    input  logic [itf_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // ch[7:0]
    output logic [itf_pkg::CH_W-1:0]           m_tdata,
    output logic                               m_tlast,
    // cut[0]
    output logic                               m_tuser
);
    import itf_pkg::*;

    itf_in_t   in_data;
    itf_desc_t front_desc;
    itf_desc_t queue_desc;
    logic      front_valid;
    logic      front_ready;
    logic      queue_valid;
    logic      queue_ready;

    // Unpack the request fields; padding bits above the flags are ignored
    assign in_data = s_tdata[$bits(itf_in_t)-1:0];

    itf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (in_data),
        .desc_valid (front_valid),
        .desc_ready (front_ready),
        .desc       (front_desc)
    );

    // Hold classified requests while the back divides and emits
    itf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_desc),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_desc)
    );

    itf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .q_ready (queue_ready),
        .q_desc  (queue_desc),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_ch    (m_tdata),
        .m_last  (m_tlast),
        .m_cut   (m_tuser)
    );
endmodule

### rtl/core/itf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module itf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/core/itf_front.sv
// Front part: accepts a request, drops a bad radix, derives magnitude, sign and prefix.
// Depends on itf_pkg.
module itf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  itf_pkg::itf_in_t  in_data,
    output logic              desc_valid,
    input  logic              desc_ready,
    output itf_pkg::itf_desc_t desc
);
    import itf_pkg::*;

    logic               fv_reg;
    itf_desc_t          desc_reg;
    itf_desc_t          desc_next;
    logic               radix_ok;
    logic               left;
    logic               neg;
    logic [VALUE_BITS-1:0] masked;
    logic [VALUE_BITS-1:0] mag;

    assign in_ready = !fv_reg || desc_ready;
    assign radix_ok = (in_data.radix >= RADIX_MIN) && (in_data.radix <= RADIX_MAX);
    assign left     = in_data.flags[FL_LEFT];
    assign masked   = in_data.value[VALUE_BITS-1:0];
    assign neg      = in_data.flags[FL_SIGN] && masked[VALUE_BITS-1];
    assign mag      = neg ? (~masked + VALUE_BITS'(1)) : masked;

    always_comb
    begin
        desc_next.mag      = MAG_W'(mag);
        desc_next.radix    = in_data.radix;
        desc_next.width    = in_data.width;
        desc_next.prec     = in_data.precision;
        desc_next.zero     = in_data.flags[FL_ZERO] && !left;
        desc_next.left     = left;
        desc_next.upper    = in_data.flags[FL_UPPER];
        desc_next.sign_en  = 1'b0;
        desc_next.sign_ch  = CH_SPACE;
        desc_next.pref_len = 2'd0;
        if (in_data.flags[FL_SIGN])
        begin
            priority if (neg)
            begin
                desc_next.sign_en = 1'b1;
                desc_next.sign_ch = CH_MINUS;
            end
            else if (in_data.flags[FL_PLUS])
            begin
                desc_next.sign_en = 1'b1;
                desc_next.sign_ch = CH_PLUS;
            end
            else if (in_data.flags[FL_SPACE])
            begin
                desc_next.sign_en = 1'b1;
                desc_next.sign_ch = CH_SPACE;
            end
            else
            begin
                desc_next.sign_en = 1'b0;
            end
        end
        if (in_data.flags[FL_PREF])
        begin
            if (in_data.radix == RADIX_HEX)
            begin
                desc_next.pref_len = 2'd2;
            end
            else if (in_data.radix == RADIX_OCT)
            begin
                desc_next.pref_len = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_valid && in_ready && radix_ok)
        begin
            fv_reg <= 1'b1;
        end
        else if (desc_ready)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && radix_ok)
        begin
            desc_reg <= desc_next;
        end
    end

    assign desc_valid = fv_reg;
    assign desc       = desc_reg;
endmodule

### rtl/core/itf_queue.sv
// Short FIFO of classified requests between the front and the back.
// Depends on itf_pkg.
module itf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  itf_pkg::itf_desc_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output itf_pkg::itf_desc_t pop_data
);
    import itf_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    itf_desc_t        slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count over depth");
    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif
endmodule

### rtl/core/itf_back.sv
// Back part: divides the magnitude into digits, lays out the text, emits characters.
// Depends on itf_pkg and itf_ram.
module itf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  itf_pkg::itf_desc_t q_desc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [itf_pkg::CH_W-1:0] m_ch,
    output logic               m_last,
    output logic               m_cut
);
    import itf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_LAY_A,
        ST_LAY_B,
        ST_RD,
        ST_WR
    } state_t;

    state_t             state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [PREC_W-1:0]  prec_reg, prec_next;
    logic               sign_en_reg, sign_en_next;
    logic [CH_W-1:0]    sign_ch_reg, sign_ch_next;
    logic [1:0]         pref_len_reg, pref_len_next;
    logic               zero_reg, zero_next;
    logic               left_reg, left_next;
    logic               upper_reg, upper_next;
    logic [BIDX_W-1:0]  bidx_reg, bidx_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [ND_W-1:0]    nd_reg, nd_next;
    logic [POS_W-1:0]   body_reg, body_next;
    logic [POS_W-1:0]   core_reg, core_next;
    logic [POS_W-1:0]   lead_end_reg, lead_end_next;
    logic [POS_W-1:0]   sign_end_reg, sign_end_next;
    logic [POS_W-1:0]   pref_end_reg, pref_end_next;
    logic [POS_W-1:0]   fill_end_reg, fill_end_next;
    logic [POS_W-1:0]   dig_end_reg, dig_end_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic               cut_reg, cut_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               ov_reg, ov_next;
    logic [CH_W-1:0]    och_reg, och_next;
    logic               olast_reg, olast_next;
    logic               ocut_reg, ocut_next;

    logic [8+DIGIT_W-1:0] div_res;
    logic [POS_W-1:0]   nd_p;
    logic [POS_W-1:0]   prec_p;
    logic [POS_W-1:0]   width_p;
    logic [POS_W-1:0]   sign_len;
    logic [POS_W-1:0]   pad;
    logic [POS_W-1:0]   total;
    logic [POS_W-1:0]   dig_addr;
    logic [CH_W-1:0]    ch_sel;
    logic               out_free;

    logic               ram_we;
    logic [DIG_AW-1:0]  ram_waddr;
    logic [DIGIT_W-1:0] ram_wdata;
    logic               ram_re;
    logic [DIGIT_W-1:0] ram_rdata;

    itf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dig_addr[DIG_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign q_ready  = (state_reg == ST_IDLE);
    assign div_res  = div_byte(rem_reg, mag_reg[{bidx_reg, 3'b000} +: 8], radix_reg);
    assign nd_p     = POS_W'(nd_reg);
    assign prec_p   = POS_W'(prec_reg);
    assign width_p  = POS_W'(width_reg);
    assign sign_len = POS_W'(sign_en_reg);
    assign pad      = (width_p > core_reg) ? (width_p - core_reg) : '0;
    assign total    = core_reg + pad;
    assign dig_addr = dig_end_reg - pos_reg - POS_W'(1);
    assign out_free = !ov_reg || m_ready;

    // Character at the current position, by text segment
    always_comb
    begin
        priority if (pos_reg < lead_end_reg)
        begin
            ch_sel = CH_SPACE;
        end
        else if (pos_reg < sign_end_reg)
        begin
            ch_sel = sign_ch_reg;
        end
        else if (pos_reg < pref_end_reg)
        begin
            ch_sel = (pos_reg == sign_end_reg) ? CH_ZERO : (upper_reg ? CH_X_UP : CH_X_LO);
        end
        else if (pos_reg < fill_end_reg)
        begin
            ch_sel = CH_ZERO;
        end
        else if (pos_reg < dig_end_reg)
        begin
            ch_sel = digit_char(ram_rdata, upper_reg);
        end
        else
        begin
            ch_sel = CH_SPACE;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        radix_next    = radix_reg;
        width_next    = width_reg;
        prec_next     = prec_reg;
        sign_en_next  = sign_en_reg;
        sign_ch_next  = sign_ch_reg;
        pref_len_next = pref_len_reg;
        zero_next     = zero_reg;
        left_next     = left_reg;
        upper_next    = upper_reg;
        bidx_next     = bidx_reg;
        rem_next      = rem_reg;
        nd_next       = nd_reg;
        body_next     = body_reg;
        core_next     = core_reg;
        lead_end_next = lead_end_reg;
        sign_end_next = sign_end_reg;
        pref_end_next = pref_end_reg;
        fill_end_next = fill_end_reg;
        dig_end_next  = dig_end_reg;
        cnt_next      = cnt_reg;
        cut_next      = cut_reg;
        pos_next      = pos_reg;
        och_next      = och_reg;
        olast_next    = olast_reg;
        ocut_next     = ocut_reg;
        ov_next       = ov_reg && !m_ready;
        ram_we        = 1'b0;
        ram_waddr     = nd_reg[DIG_AW-1:0];
        ram_wdata     = rem_reg;
        ram_re        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    mag_next      = q_desc.mag;
                    radix_next    = q_desc.radix;
                    width_next    = q_desc.width;
                    prec_next     = q_desc.prec;
                    sign_en_next  = q_desc.sign_en;
                    sign_ch_next  = q_desc.sign_ch;
                    pref_len_next = q_desc.pref_len;
                    zero_next     = q_desc.zero;
                    left_next     = q_desc.left;
                    upper_next    = q_desc.upper;
                    nd_next       = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (mag_reg == '0)
                begin
                    // A zero value still prints one digit
                    if (nd_reg == '0)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                        nd_next   = ND_W'(1);
                    end
                    state_next = ST_LAY_A;
                end
                else
                begin
                    bidx_next  = top_byte(mag_reg);
                    rem_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next[{bidx_reg, 3'b000} +: 8] = div_res[8+DIGIT_W-1:DIGIT_W];
                rem_next = div_res[DIGIT_W-1:0];
                if (bidx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = div_res[DIGIT_W-1:0];
                    nd_next    = nd_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    bidx_next = bidx_reg - 1'b1;
                end
            end
            ST_LAY_A:
            begin
                body_next  = (nd_p > prec_p) ? nd_p : prec_p;
                core_next  = ((nd_p > prec_p) ? nd_p : prec_p) + sign_len
                             + POS_W'(pref_len_reg);
                state_next = ST_LAY_B;
            end
            ST_LAY_B:
            begin
                lead_end_next = (zero_reg || left_reg) ? '0 : pad;
                sign_end_next = ((zero_reg || left_reg) ? '0 : pad) + sign_len;
                pref_end_next = ((zero_reg || left_reg) ? '0 : pad) + sign_len
                                + POS_W'(pref_len_reg);
                dig_end_next  = total - (left_reg ? pad : '0);
                fill_end_next = total - (left_reg ? pad : '0) - nd_p;
                cut_next      = (total > MAX_CHARS_P);
                cnt_next      = (total > MAX_CHARS_P) ? MAX_CHARS_P : total;
                pos_next      = '0;
                state_next    = ST_RD;
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    och_next   = ch_sel;
                    olast_next = (pos_reg == cnt_reg - POS_W'(1));
                    ocut_next  = cut_reg;
                    if (pos_reg == cnt_reg - POS_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mag_reg      <= '0;
            radix_reg    <= RADIX_MIN;
            width_reg    <= '0;
            prec_reg     <= '0;
            sign_en_reg  <= 1'b0;
            sign_ch_reg  <= CH_SPACE;
            pref_len_reg <= '0;
            zero_reg     <= 1'b0;
            left_reg     <= 1'b0;
            upper_reg    <= 1'b0;
            bidx_reg     <= '0;
            rem_reg      <= '0;
            nd_reg       <= '0;
            body_reg     <= '0;
            core_reg     <= '0;
            lead_end_reg <= '0;
            sign_end_reg <= '0;
            pref_end_reg <= '0;
            fill_end_reg <= '0;
            dig_end_reg  <= '0;
            cnt_reg      <= '0;
            cut_reg      <= 1'b0;
            pos_reg      <= '0;
            ov_reg       <= 1'b0;
            och_reg      <= '0;
            olast_reg    <= 1'b0;
            ocut_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mag_reg      <= mag_next;
            radix_reg    <= radix_next;
            width_reg    <= width_next;
            prec_reg     <= prec_next;
            sign_en_reg  <= sign_en_next;
            sign_ch_reg  <= sign_ch_next;
            pref_len_reg <= pref_len_next;
            zero_reg     <= zero_next;
            left_reg     <= left_next;
            upper_reg    <= upper_next;
            bidx_reg     <= bidx_next;
            rem_reg      <= rem_next;
            nd_reg       <= nd_next;
            body_reg     <= body_next;
            core_reg     <= core_next;
            lead_end_reg <= lead_end_next;
            sign_end_reg <= sign_end_next;
            pref_end_reg <= pref_end_next;
            fill_end_reg <= fill_end_next;
            dig_end_reg  <= dig_end_next;
            cnt_reg      <= cnt_next;
            cut_reg      <= cut_next;
            pos_reg      <= pos_next;
            ov_reg       <= ov_next;
            och_reg      <= och_next;
            olast_reg    <= olast_next;
            ocut_reg     <= ocut_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_ch    = och_reg;
    assign m_last  = olast_reg;
    assign m_cut   = ocut_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < radix_reg))
        else $error("division remainder not below radix");
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= ND_W'(VALUE_BITS))
        else $error("digit count over value width");
    a_pos_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (pos_reg < cnt_reg && cnt_reg <= MAX_CHARS_P))
        else $error("emit position outside text");
    a_body_covers_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAY_B) |-> (body_reg >= nd_p && core_reg >= body_reg))
        else $error("digit body shorter than digit count");
`endif
endmodule
